### hdl/text_terminal_cursor_scroll_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text terminal
// Immediate-implication and next-cycle-implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_TERMINAL_CURSOR_SCROLL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTCS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ttcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_pkg
// Types and constants shared by the text terminal.
// ----------------------------------------------------------------------------
package ttcs_pkg;

  localparam int CMD_W   = 2;
  localparam int ATTR_W  = 8;
  localparam int AWID_W  = 7;
  localparam int AHGT_W  = 5;
  localparam int CELL_W  = 16;
  localparam int CURX_W  = 7;
  localparam int CURY_W  = 5;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ATTR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd112;
  localparam logic [AWID_W-1:0] WIDTH_RESET  = 7'd80;
  localparam logic [AHGT_W-1:0] HEIGHT_RESET = 5'd25;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

### hdl/ttcs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ttcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/text_terminal_cursor_scroll.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll
// Text-mode terminal: character cell store, cursor, wrap and scroll.
// ----------------------------------------------------------------------------
//  channel | direction | carries
//  --------+-----------+--------------------------------------------------
//  s_*     | in        | request: command in tuser; char, column, row
//  m_*     | out       | result: cell data, cursor column, cursor row
//  cfg_*   | in        | register write: attribute, width, height
//
// A request is taken only in IDLE. Set, put and unused commands pass EXEC and
// DONE, a read in the area EXEC, READ_WAIT and DONE; IDLE returns as the result
// loads, so no request is taken while the last one is in work. A scroll reads
// each cell below the top row and writes it one row up, then blanks the last
// row, through one address unit and one RAM port pair. rst is synchronous and
// leaves the cell store as is. A stalled result holds in the output register;
// DONE waits until it frees.
module text_terminal_cursor_scroll #(
  parameter int MAX_COLUMNS = 80,
  parameter int MAX_ROWS    = 25
) (
  input  logic                             clk,
  input  logic                             rst,
  // request: s_tdata = char_code[7:0], column[7:0], row[7:0], from bit 0 up
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ttcs_pkg::IN_W-1:0]        s_tdata,
  // s_tuser = command[1:0]
  input  logic [ttcs_pkg::CMD_W-1:0]       s_tuser,
  // result: m_tdata = cell_data[15:0], cursor_column[6:0], cursor_row[4:0],
  // zero pad, from bit 0 up
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ttcs_pkg::OUT_W-1:0]       m_tdata,
  input  logic                             cfg_we,
  input  logic [ttcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import ttcs_pkg::*;

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = AW + 9;

  // configuration
  logic [ATTR_W-1:0] cell_attribute;
  logic [AWID_W-1:0] active_width;
  logic [AHGT_W-1:0] active_height;

  // sequencer and captured request
  state_t state, state_next;
  logic [CMD_W-1:0]  cmd;
  logic [7:0]        ch;
  logic [7:0]        col_in;
  logic [7:0]        row_in;

  // cursor and scroll counters
  logic [CURX_W-1:0] cursor_x;
  logic [CURY_W-1:0] cursor_y;
  logic [CURX_W-1:0] scroll_col;
  logic [CURY_W-1:0] scroll_row;
  logic [CELL_W-1:0] cell_data;

  // address unit and RAM ports
  logic [7:0]        addr_col;
  logic [7:0]        addr_row;
  logic [PW-1:0]     addr_wide;
  logic [AW-1:0]     ram_addr;
  logic              ram_we;
  logic              ram_re;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;

  // derived decisions
  logic [AWID_W-1:0] w_use;
  logic [AHGT_W-1:0] h_use;
  logic [AWID_W-1:0] w_last;
  logic [AHGT_W-1:0] h_last;
  logic              is_newline;
  logic              wrap;
  logic              at_bottom;
  logic              in_area;
  logic              put_write;
  logic              col_end;
  logic              row_end;
  logic              out_free;
  logic              accept;

  // Clamp the sizes in use to 1..MAX.
  always_comb begin
    if (active_width == '0) begin
      w_use = AWID_W'(1);
    end else if (9'(active_width) > 9'(MAX_COLUMNS)) begin
      w_use = AWID_W'(MAX_COLUMNS);
    end else begin
      w_use = active_width;
    end
    if (active_height == '0) begin
      h_use = AHGT_W'(1);
    end else if (7'(active_height) > 7'(MAX_ROWS)) begin
      h_use = AHGT_W'(MAX_ROWS);
    end else begin
      h_use = active_height;
    end
  end

  assign w_last     = w_use - AWID_W'(1);
  assign h_last     = h_use - AHGT_W'(1);
  assign is_newline = (ch == CHAR_NEWLINE);
  // Wrap on newline or at/past the last column in use.
  assign wrap       = is_newline || (cursor_x >= w_last);
  assign at_bottom  = (cursor_y >= h_last);
  assign in_area    = (col_in < 8'(w_use)) && (row_in < 8'(h_use));
  assign put_write  = !is_newline && (9'(cursor_x) < 9'(MAX_COLUMNS))
                      && (7'(cursor_y) < 7'(MAX_ROWS));
  assign col_end    = (scroll_col == w_last);
  assign row_end    = (scroll_row == h_last);
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;

  // Shared address unit: row * MAX_COLUMNS + column.
  assign addr_wide = PW'(addr_row) * PW'(MAX_COLUMNS) + PW'(addr_col);
  assign ram_addr  = addr_wide[AW-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd)
          CMD_PUT: begin
            if (wrap && at_bottom) begin
              state_next = (h_last == '0) ? ST_FILL : ST_SCROLL_RD;
            end else begin
              state_next = ST_DONE;
            end
          end
          CMD_READ: state_next = in_area ? ST_READ_WAIT : ST_DONE;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_READ_WAIT: state_next = ST_DONE;
      ST_SCROLL_RD: state_next = ST_SCROLL_WR;
      ST_SCROLL_WR: begin
        state_next = (col_end && row_end) ? ST_FILL : ST_SCROLL_RD;
      end
      ST_FILL: begin
        if (col_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM controls and address unit inputs.
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = {cell_attribute, ch};
    addr_col  = 8'(cursor_x);
    addr_row  = 8'(cursor_y);
    case (state)
      ST_EXEC: begin
        if (cmd == CMD_PUT) begin
          ram_we = put_write;
        end else if (cmd == CMD_READ) begin
          ram_re   = in_area;
          addr_col = col_in;
          addr_row = row_in;
        end
      end
      ST_SCROLL_RD: begin
        ram_re   = 1'b1;
        addr_col = 8'(scroll_col);
        addr_row = 8'(scroll_row);
      end
      ST_SCROLL_WR: begin
        // move the cell just read up one row
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        addr_col  = 8'(scroll_col);
        addr_row  = 8'(scroll_row - CURY_W'(1));
      end
      ST_FILL: begin
        // blank the last row with attributed spaces
        ram_we    = 1'b1;
        ram_wdata = {cell_attribute, CHAR_SPACE};
        addr_col  = 8'(scroll_col);
        addr_row  = 8'(h_last);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ttcs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // Control registers: state, configuration, cursor, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cell_attribute <= ATTR_RESET;
      active_width   <= WIDTH_RESET;
      active_height  <= HEIGHT_RESET;
      cursor_x       <= '0;
      cursor_y       <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_ATTR:   cell_attribute <= cfg_data[ATTR_W-1:0];
          REG_WIDTH:  active_width   <= cfg_data[AWID_W-1:0];
          REG_HEIGHT: active_height  <= cfg_data[AHGT_W-1:0];
          default:    ;
        endcase
      end

      case (state)
        ST_EXEC: begin
          if (cmd == CMD_PUT) begin
            // advance, wrap to the next row; a scroll sets the cursor at its end
            if (!wrap) begin
              cursor_x <= cursor_x + CURX_W'(1);
            end else if (!at_bottom) begin
              cursor_x <= '0;
              cursor_y <= cursor_y + CURY_W'(1);
            end
          end else if (cmd == CMD_SET && in_area) begin
            cursor_x <= col_in[CURX_W-1:0];
            cursor_y <= row_in[CURY_W-1:0];
          end
        end
        ST_FILL: begin
          if (col_end) begin
            cursor_x <= '0;
            cursor_y <= h_last;
          end
        end
        default: ;
      endcase

      // Hold the result until taken; load a new one when the register frees.
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd    <= s_tuser;
      ch     <= s_tdata[7:0];
      col_in <= s_tdata[15:8];
      row_in <= s_tdata[23:16];
    end

    case (state)
      ST_EXEC: begin
        cell_data  <= '0;
        scroll_col <= '0;
        scroll_row <= CURY_W'(1);
      end
      ST_READ_WAIT: begin
        cell_data <= ram_rdata;
      end
      ST_SCROLL_WR: begin
        if (col_end) begin
          scroll_col <= '0;
          scroll_row <= scroll_row + CURY_W'(1);
        end else begin
          scroll_col <= scroll_col + CURX_W'(1);
        end
      end
      ST_FILL: begin
        scroll_col <= scroll_col + CURX_W'(1);
      end
      default: ;
    endcase

    if (state == ST_DONE && out_free) begin
      m_tdata <= {(OUT_W - CELL_W - CURX_W - CURY_W)'(0), cursor_y, cursor_x, cell_data};
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "text_terminal_cursor_scroll_assert.svh"

  `TTCS_ASSERT_SAME(a_cursor_in_store, clk, rst, 1'b1,
    (9'(cursor_x) < 9'(MAX_COLUMNS)) && (7'(cursor_y) < 7'(MAX_ROWS)),
    "cursor left the cell store")
  `TTCS_ASSERT_SAME(a_ram_addr_range, clk, rst, ram_we || ram_re,
    PW'(ram_addr) < PW'(DEPTH), "cell address past the store")
  `TTCS_ASSERT_NEXT(a_accept_starts, clk, rst, accept, state == ST_EXEC,
    "accepted request did not start execution")
  `TTCS_ASSERT_NEXT(a_result_loaded, clk, rst, state == ST_DONE && out_free,
    m_tvalid && state == ST_IDLE, "finished item did not present a result")

endmodule
